// ===== rtl/core/swc_pkg.sv =====
// shared constants, command and status types for the swerve wheel command generator
`default_nettype none
package swc_pkg;

    // defaults for top level parameters
    localparam int NUM_WHEELS_DEF   = 4;
    localparam int CORDIC_STEPS_DEF = 16;

    // fixed wheel count of the register and input set
    localparam int MAX_WHEELS = 4;
    localparam int TABLE_LEN  = 24;
    localparam int ITER_W     = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TURN = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM0     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM1     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM2     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM3     = 4'd7;

    // angle constants
    localparam logic signed [23:0] PI_Q12      = 24'sd12868;
    localparam logic signed [23:0] HALF_PI_Q12 = 24'sd6434;
    localparam logic signed [23:0] TWO_PI_Q12  = 24'sd25736;
    localparam logic signed [23:0] WRAP_BIG    = 24'sd411776;
    localparam logic signed [23:0] WRAP_BIG_TH = 24'sd398908;
    localparam logic signed [35:0] PI_Q24      = 36'sd52707179;
    localparam logic signed [35:0] INV_GAIN    = 36'sd652032874;

    // datapath operation codes
    localparam logic [3:0] OP_IDLE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_MUL_PY = 4'd2;
    localparam logic [3:0] OP_MUL_PX = 4'd3;
    localparam logic [3:0] OP_SQ_X   = 4'd4;
    localparam logic [3:0] OP_SQ_Y   = 4'd5;
    localparam logic [3:0] OP_START  = 4'd6;
    localparam logic [3:0] OP_RUN    = 4'd7;
    localparam logic [3:0] OP_ANGLE  = 4'd8;
    localparam logic [3:0] OP_WRAP   = 4'd9;
    localparam logic [3:0] OP_FLIP   = 4'd10;
    localparam logic [3:0] OP_COS    = 4'd11;
    localparam logic [3:0] OP_MUL_M  = 4'd12;
    localparam logic [3:0] OP_MUL_R  = 4'd13;
    localparam logic [3:0] OP_EMIT   = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] widx;
        logic       last;
    } swc_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic sqrt_done;
        logic wrap_ok;
        logic out_free;
    } swc_sts_t;

    // arctangent table, Q.24
    function automatic logic signed [31:0] atan_q24(input logic [ITER_W-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd13176795;
            5'd1:  v = 32'sd7778716;
            5'd2:  v = 32'sd4110060;
            5'd3:  v = 32'sd2086331;
            5'd4:  v = 32'sd1047214;
            5'd5:  v = 32'sd524117;
            5'd6:  v = 32'sd262123;
            5'd7:  v = 32'sd131069;
            5'd8:  v = 32'sd65536;
            5'd9:  v = 32'sd32768;
            5'd10: v = 32'sd16384;
            5'd11: v = 32'sd8192;
            5'd12: v = 32'sd4096;
            5'd13: v = 32'sd2048;
            5'd14: v = 32'sd1024;
            5'd15: v = 32'sd512;
            5'd16: v = 32'sd256;
            5'd17: v = 32'sd128;
            5'd18: v = 32'sd64;
            5'd19: v = 32'sd32;
            5'd20: v = 32'sd16;
            5'd21: v = 32'sd8;
            5'd22: v = 32'sd4;
            5'd23: v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/swc_ctrl.sv =====
// sequencer that steps the datapath through each wheel of a tick
`default_nettype none
module swc_ctrl #(
    parameter int NUM_WHEELS = swc_pkg::NUM_WHEELS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire swc_pkg::swc_sts_t sts,
    output swc_pkg::swc_cmd_t     cmd
);

    localparam int USED = (NUM_WHEELS < swc_pkg::MAX_WHEELS) ? NUM_WHEELS : swc_pkg::MAX_WHEELS;
    localparam logic [1:0] LAST_IDX = 2'(USED - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MY    = 4'd1;
    localparam logic [3:0] S_MX    = 4'd2;
    localparam logic [3:0] S_WY    = 4'd3;
    localparam logic [3:0] S_SQY   = 4'd4;
    localparam logic [3:0] S_START = 4'd5;
    localparam logic [3:0] S_RUN   = 4'd6;
    localparam logic [3:0] S_ANGLE = 4'd7;
    localparam logic [3:0] S_WRAP  = 4'd8;
    localparam logic [3:0] S_FLIP  = 4'd9;
    localparam logic [3:0] S_COS   = 4'd10;
    localparam logic [3:0] S_CVAL  = 4'd11;
    localparam logic [3:0] S_MULM  = 4'd12;
    localparam logic [3:0] S_MULR  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] widx_reg, widx_next;
    logic [3:0] op;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        op         = swc_pkg::OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = swc_pkg::OP_LOAD;
                    widx_next  = 2'd0;
                    state_next = S_MY;
                end
            end
            S_MY:    begin op = swc_pkg::OP_MUL_PY; state_next = S_MX;    end
            S_MX:    begin op = swc_pkg::OP_MUL_PX; state_next = S_WY;    end
            S_WY:    begin op = swc_pkg::OP_SQ_X;   state_next = S_SQY;   end
            S_SQY:   begin op = swc_pkg::OP_SQ_Y;   state_next = S_START; end
            S_START: begin op = swc_pkg::OP_START;  state_next = S_RUN;   end
            S_RUN:
            begin
                op = swc_pkg::OP_RUN;
                if (sts.cordic_done && sts.sqrt_done)
                begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin op = swc_pkg::OP_ANGLE;  state_next = S_WRAP;  end
            S_WRAP:
            begin
                op = swc_pkg::OP_WRAP;
                if (sts.wrap_ok)
                begin
                    state_next = S_FLIP;
                end
            end
            S_FLIP:  begin op = swc_pkg::OP_FLIP;   state_next = S_COS;   end
            S_COS:
            begin
                op = swc_pkg::OP_RUN;
                if (sts.cordic_done)
                begin
                    state_next = S_CVAL;
                end
            end
            S_CVAL:  begin op = swc_pkg::OP_COS;    state_next = S_MULM;  end
            S_MULM:  begin op = swc_pkg::OP_MUL_M;  state_next = S_MULR;  end
            S_MULR:  begin op = swc_pkg::OP_MUL_R;  state_next = S_EMIT;  end
            S_EMIT:
            begin
                op = swc_pkg::OP_EMIT;
                if (sts.out_free)
                begin
                    if (widx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        widx_next  = widx_reg + 2'd1;
                        state_next = S_MY;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            widx_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cmd.op   = op;
    assign cmd.widx = widx_reg;
    assign cmd.last = (widx_reg == LAST_IDX);

endmodule
`default_nettype wire

// ===== rtl/core/swc_dp.sv =====
// datapath: ramps, shared multiplier, cordic, square root, angle wrap, output register
`default_nettype none
module swc_dp #(
    parameter int CORDIC_STEPS = swc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [swc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic signed [15:0]             target_vx,
    input  wire logic signed [15:0]             target_vy,
    input  wire logic signed [15:0]             target_turn,
    input  wire logic [15:0]                    command_age,
    input  wire logic signed [17:0]             steer_now_0,
    input  wire logic signed [17:0]             steer_now_1,
    input  wire logic signed [17:0]             steer_now_2,
    input  wire logic signed [17:0]             steer_now_3,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [1:0]                          wheel_index,
    output logic signed [17:0]                  steer_target,
    output logic signed [23:0]                  roll_target,
    output logic                                timed_out,
    output logic                                last_wheel,
    input  wire swc_pkg::swc_cmd_t              cmd,
    output swc_pkg::swc_sts_t                   sts
);

    localparam logic [swc_pkg::ITER_W-1:0] STEPS = swc_pkg::ITER_W'(CORDIC_STEPS);

    // configuration registers
    logic [15:0] timeout_reg;
    logic [11:0] step_x_reg, step_y_reg, step_t_reg;
    logic [63:0] geom_reg [swc_pkg::MAX_WHEELS];

    // tick state
    logic signed [15:0] ramp_x_reg, ramp_y_reg, ramp_t_reg;
    logic signed [15:0] vx_reg, vy_reg, wz_reg;
    logic               stale_reg;
    logic signed [17:0] now_reg [swc_pkg::MAX_WHEELS];

    // per wheel working registers
    logic signed [60:0] prod_reg;
    logic signed [19:0] wx_reg, wy_reg;
    logic [39:0]        sq_reg;
    logic [39:0]        sv_reg, sr_reg, sbit_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [swc_pkg::ITER_W-1:0] cnt_reg;
    logic               rot_reg, zero_reg, neg_reg;
    logic signed [20:0] ang_reg;
    logic signed [21:0] m_reg;
    logic signed [17:0] steer_reg, cos_reg;

    // output register
    logic               out_valid_reg;
    logic [1:0]         widx_out_reg;
    logic signed [17:0] steer_out_reg;
    logic signed [23:0] roll_out_reg;
    logic               stale_out_reg, last_out_reg;

    function automatic logic signed [15:0] ramp(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [11:0] step);
        logic signed [16:0] d;
        logic signed [16:0] s;
        d = 17'(tgt) - 17'(cur);
        s = signed'({5'b0, step});
        if (d > s)
            d = s;
        else if (d < -s)
            d = -s;
        return 16'(17'(cur) + d);
    endfunction

    // selected wheel geometry
    logic [63:0]        geom;
    logic signed [15:0] px, py;
    logic signed [17:0] off;
    logic [13:0]        invr;
    logic signed [17:0] now;
    assign geom = geom_reg[cmd.widx];
    assign px   = signed'(geom[15:0]);
    assign py   = signed'(geom[31:16]);
    assign off  = signed'(geom[49:32]);
    assign invr = geom[63:50];
    assign now  = now_reg[cmd.widx];

    // ramps for the incoming tick
    logic               stale_in;
    logic signed [15:0] nx, ny, nt;
    assign stale_in = command_age > timeout_reg;
    assign nx = ramp(ramp_x_reg, target_vx, step_x_reg);
    assign ny = ramp(ramp_y_reg, target_vy, step_y_reg);
    assign nt = ramp(ramp_t_reg, target_turn, step_t_reg);

    // shared multiplier operands
    logic signed [39:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [60:0] mul_p;
    always_comb
    begin
        mul_a = 40'(wz_reg);
        mul_b = 21'(py);
        case (cmd.op)
            swc_pkg::OP_MUL_PX: begin mul_a = 40'(wz_reg); mul_b = 21'(px);     end
            swc_pkg::OP_SQ_X:   begin mul_a = 40'(wx_reg); mul_b = 21'(wx_reg); end
            swc_pkg::OP_SQ_Y:   begin mul_a = 40'(wy_reg); mul_b = 21'(wy_reg); end
            swc_pkg::OP_MUL_M:
            begin
                mul_a = signed'({20'b0, sr_reg[19:0]});
                mul_b = 21'(cos_reg);
            end
            swc_pkg::OP_MUL_R:
            begin
                mul_a = prod_reg[39:0];
                mul_b = signed'({7'b0, invr});
            end
            default: begin mul_a = 40'(wz_reg); mul_b = 21'(py); end
        endcase
    end
    assign mul_p = 61'(mul_a) * 61'(mul_b);

    // rounded product terms
    logic signed [60:0] prod_r12, prod_r24;
    assign prod_r12 = (prod_reg + 61'sd2048) >>> 12;
    assign prod_r24 = (prod_reg + 61'sd8388608) >>> 24;

    // cordic step
    logic signed [35:0] cdx, cdy;
    logic               cdir, cdone;
    logic signed [31:0] catan;
    assign cdx   = cy_reg >>> cnt_reg;
    assign cdy   = cx_reg >>> cnt_reg;
    assign cdir  = rot_reg ? (cz_reg >= 32'sd0) : !(cy_reg > 36'sd0);
    assign catan = swc_pkg::atan_q24(cnt_reg);
    assign cdone = (cnt_reg == STEPS);

    // vectoring start values
    logic signed [35:0] xs, ys;
    assign xs = 36'(wx_reg) <<< 12;
    assign ys = 36'(wy_reg) <<< 12;

    // square root step
    logic [39:0] s_sum;
    assign s_sum = sr_reg + sbit_reg;

    // angle and wrap
    logic signed [31:0] z_r;
    logic signed [20:0] ang_w;
    logic               wrap_ok;
    assign z_r     = (cz_reg + 32'sd2048) >>> 12;
    assign ang_w   = (zero_reg ? 21'sd0 : 21'(z_r)) + 21'(off);
    assign wrap_ok = (24'(m_reg) >= -swc_pkg::PI_Q12) && (24'(m_reg) < swc_pkg::PI_Q12);

    // candidate choice
    logic signed [23:0] ma, mb, abs_a, abs_b, sel, red;
    logic               red_neg;
    always_comb
    begin
        ma    = 24'(m_reg);
        mb    = (ma >= 24'sd0) ? ma - swc_pkg::PI_Q12 : ma + swc_pkg::PI_Q12;
        abs_a = (ma < 24'sd0) ? -ma : ma;
        abs_b = (mb < 24'sd0) ? -mb : mb;
        sel   = (abs_a < abs_b) ? 24'(ang_reg) : 24'(ang_reg) + swc_pkg::PI_Q12;
        red     = ma;
        red_neg = 1'b0;
        if (ma > swc_pkg::HALF_PI_Q12)
        begin
            red     = ma - swc_pkg::PI_Q12;
            red_neg = 1'b1;
        end
        else if (ma < -swc_pkg::HALF_PI_Q12)
        begin
            red     = ma + swc_pkg::PI_Q12;
            red_neg = 1'b1;
        end
    end

    // cosine rounding
    logic signed [35:0] x_r;
    assign x_r = (cx_reg + 36'sd8192) >>> 14;

    // saturated roll
    logic signed [23:0] roll_sat;
    always_comb
    begin
        if (prod_r24 > 61'sd8388607)
            roll_sat = 24'sd8388607;
        else if (prod_r24 < -61'sd8388608)
            roll_sat = -24'sd8388608;
        else
            roll_sat = 24'(prod_r24);
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // configuration, ramp state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 16'd100;
            step_x_reg    <= 12'd4;
            step_y_reg    <= 12'd4;
            step_t_reg    <= 12'd4;
            geom_reg[0]   <= 64'd0;
            geom_reg[1]   <= 64'd0;
            geom_reg[2]   <= 64'd0;
            geom_reg[3]   <= 64'd0;
            ramp_x_reg    <= 16'sd0;
            ramp_y_reg    <= 16'sd0;
            ramp_t_reg    <= 16'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    swc_pkg::REG_TIMEOUT:   timeout_reg <= cfg_data[15:0];
                    swc_pkg::REG_STEP_X:    step_x_reg  <= cfg_data[11:0];
                    swc_pkg::REG_STEP_Y:    step_y_reg  <= cfg_data[11:0];
                    swc_pkg::REG_STEP_TURN: step_t_reg  <= cfg_data[11:0];
                    swc_pkg::REG_GEOM0:     geom_reg[0] <= cfg_data;
                    swc_pkg::REG_GEOM1:     geom_reg[1] <= cfg_data;
                    swc_pkg::REG_GEOM2:     geom_reg[2] <= cfg_data;
                    swc_pkg::REG_GEOM3:     geom_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == swc_pkg::OP_LOAD && !stale_in)
            begin
                ramp_x_reg <= nx;
                ramp_y_reg <= ny;
                ramp_t_reg <= nt;
            end
            if (cmd.op == swc_pkg::OP_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            swc_pkg::OP_LOAD:
            begin
                stale_reg  <= stale_in;
                vx_reg     <= stale_in ? 16'sd0 : nx;
                vy_reg     <= stale_in ? 16'sd0 : ny;
                wz_reg     <= stale_in ? 16'sd0 : nt;
                now_reg[0] <= steer_now_0;
                now_reg[1] <= steer_now_1;
                now_reg[2] <= steer_now_2;
                now_reg[3] <= steer_now_3;
            end
            swc_pkg::OP_MUL_PY:
            begin
                prod_reg <= mul_p;
            end
            swc_pkg::OP_MUL_PX:
            begin
                wx_reg   <= 20'(vx_reg) - 20'(prod_r12);
                prod_reg <= mul_p;
            end
            swc_pkg::OP_SQ_X:
            begin
                wy_reg   <= 20'(vy_reg) + 20'(prod_r12);
                prod_reg <= mul_p;
            end
            swc_pkg::OP_SQ_Y:
            begin
                sq_reg   <= 40'(prod_reg);
                prod_reg <= mul_p;
            end
            swc_pkg::OP_START:
            begin
                sv_reg   <= sq_reg + 40'(prod_reg);
                sr_reg   <= 40'd0;
                sbit_reg <= 40'd1 << 38;
                zero_reg <= (wx_reg == 20'sd0) && (wy_reg == 20'sd0);
                rot_reg  <= 1'b0;
                cnt_reg  <= '0;
                if (wx_reg < 20'sd0)
                begin
                    cx_reg <= -xs;
                    cy_reg <= -ys;
                    cz_reg <= (wy_reg >= 20'sd0) ? 32'(swc_pkg::PI_Q24)
                                                 : -32'(swc_pkg::PI_Q24);
                end
                else
                begin
                    cx_reg <= xs;
                    cy_reg <= ys;
                    cz_reg <= 32'sd0;
                end
            end
            swc_pkg::OP_RUN:
            begin
                if (!cdone)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cdir)
                    begin
                        cx_reg <= cx_reg - cdx;
                        cy_reg <= cy_reg + cdy;
                        cz_reg <= cz_reg - catan;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cdx;
                        cy_reg <= cy_reg - cdy;
                        cz_reg <= cz_reg + catan;
                    end
                end
                if (sbit_reg != 40'd0)
                begin
                    sbit_reg <= sbit_reg >> 2;
                    if (sv_reg >= s_sum)
                    begin
                        sv_reg <= sv_reg - s_sum;
                        sr_reg <= (sr_reg >> 1) + sbit_reg;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                end
            end
            swc_pkg::OP_ANGLE:
            begin
                ang_reg <= ang_w;
                m_reg   <= 22'(ang_w) - 22'(now);
            end
            swc_pkg::OP_WRAP:
            begin
                if (24'(m_reg) >= swc_pkg::WRAP_BIG_TH)
                    m_reg <= 22'(24'(m_reg) - swc_pkg::WRAP_BIG);
                else if (24'(m_reg) >= swc_pkg::PI_Q12)
                    m_reg <= 22'(24'(m_reg) - swc_pkg::TWO_PI_Q12);
                else if (24'(m_reg) < -swc_pkg::WRAP_BIG_TH)
                    m_reg <= 22'(24'(m_reg) + swc_pkg::WRAP_BIG);
                else if (24'(m_reg) < -swc_pkg::PI_Q12)
                    m_reg <= 22'(24'(m_reg) + swc_pkg::TWO_PI_Q12);
            end
            swc_pkg::OP_FLIP:
            begin
                if (sel > 24'sd131071)
                    steer_reg <= 18'sd131071;
                else if (sel < -24'sd131072)
                    steer_reg <= -18'sd131072;
                else
                    steer_reg <= 18'(sel);
                neg_reg <= red_neg;
                rot_reg <= 1'b1;
                cnt_reg <= '0;
                cx_reg  <= swc_pkg::INV_GAIN;
                cy_reg  <= 36'sd0;
                cz_reg  <= 32'(red) <<< 12;
            end
            swc_pkg::OP_COS:
            begin
                cos_reg <= neg_reg ? -18'(x_r) : 18'(x_r);
            end
            swc_pkg::OP_MUL_M:
            begin
                prod_reg <= mul_p;
            end
            swc_pkg::OP_MUL_R:
            begin
                prod_reg <= mul_p;
            end
            swc_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    widx_out_reg  <= cmd.widx;
                    steer_out_reg <= steer_reg;
                    roll_out_reg  <= roll_sat;
                    stale_out_reg <= stale_reg;
                    last_out_reg  <= cmd.last;
                end
            end
            default: ;
        endcase
    end

    assign sts.cordic_done = cdone;
    assign sts.sqrt_done   = (sbit_reg == 40'd0);
    assign sts.wrap_ok     = wrap_ok;
    assign sts.out_free    = out_free;

    assign out_valid    = out_valid_reg;
    assign wheel_index  = widx_out_reg;
    assign steer_target = steer_out_reg;
    assign roll_target  = roll_out_reg;
    assign timed_out    = stale_out_reg;
    assign last_wheel   = last_out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/swerve_wheel_command_generator_unit.sv =====
// top level of the swerve wheel command generator
// Each accepted tick ramps the chassis command, or zeroes it if command_age exceeds
// the timeout, and then yields one steer and roll command per wheel, wheel 0 first,
// one wheel at a time. For each wheel the sequencer runs the multiplies and setup,
// then the atan2 CORDIC and the square root side by side, then forms the angle. The
// angle wrap repeats, taking longer the farther the angle is from the measured steer
// angle, until the difference lies in [-pi, pi). Then come the flip choice, the cosine
// CORDIC pass, the cosine rounding, the two roll products and the output register.
// Loading a wheel's result waits while the output register is held by stall.
// The input stays stalled from the accepted transaction until the last wheel
// command has been loaded into the output register.
`default_nettype none
module swerve_wheel_command_generator_unit #(
    parameter int NUM_WHEELS   = swc_pkg::NUM_WHEELS_DEF,
    parameter int CORDIC_STEPS = swc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [swc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [swc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [15:0]             target_vx,
    input  wire logic signed [15:0]             target_vy,
    input  wire logic signed [15:0]             target_turn,
    input  wire logic [15:0]                    command_age,
    input  wire logic signed [17:0]             steer_now_0,
    input  wire logic signed [17:0]             steer_now_1,
    input  wire logic signed [17:0]             steer_now_2,
    input  wire logic signed [17:0]             steer_now_3,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          wheel_index,
    output logic signed [17:0]                  steer_target,
    output logic signed [23:0]                  roll_target,
    output logic                                timed_out,
    output logic                                last_wheel
);

    swc_pkg::swc_cmd_t cmd;
    swc_pkg::swc_sts_t sts;

    // sequencer
    swc_ctrl #(
        .NUM_WHEELS (NUM_WHEELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    swc_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_vx    (target_vx),
        .target_vy    (target_vy),
        .target_turn  (target_turn),
        .command_age  (command_age),
        .steer_now_0  (steer_now_0),
        .steer_now_1  (steer_now_1),
        .steer_now_2  (steer_now_2),
        .steer_now_3  (steer_now_3),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .wheel_index  (wheel_index),
        .steer_target (steer_target),
        .roll_target  (roll_target),
        .timed_out    (timed_out),
        .last_wheel   (last_wheel),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
`default_nettype wire

// ===== rtl/core/swc_chk.sv =====
// port level checker for the swerve wheel command generator, with its bind
`default_nettype none
module swc_chk #(
    parameter int NUM_WHEELS = swc_pkg::NUM_WHEELS_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         wheel_index,
    input wire logic signed [17:0] steer_target,
    input wire logic signed [23:0] roll_target,
    input wire logic               last_wheel
);

    localparam int USED = (NUM_WHEELS < swc_pkg::MAX_WHEELS) ? NUM_WHEELS
                                                              : swc_pkg::MAX_WHEELS;
    localparam logic [1:0] LAST_IDX = 2'(USED - 1);

    // a transaction on the input starts work that stalls the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transaction");

    // the last result of a tick is the last wheel
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_wheel) |-> (wheel_index == LAST_IDX))
        else $error("last wheel flag on wrong wheel");

    // while a tick still has wheels to go, no new input is taken
    a_tick_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_wheel) |-> in_stall)
        else $error("input open with wheels pending");

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(roll_target)
                                      && $stable(steer_target)))
        else $error("held result changed");

endmodule

bind swerve_wheel_command_generator_unit swc_chk #(
    .NUM_WHEELS (NUM_WHEELS)
) u_swc_chk (.*);
`default_nettype wire
